FILE: hdl/assert_macros.svh
// Assertion helpers for the wind rotation block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checks that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Checks that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

FILE: hdl/gwr_pkg.sv
// ----------------------------------------------------------------------------
// Wind rotation package
// Shared constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none
package gwr_pkg;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int MAX_STAGES = 24;
    localparam logic [15:0] CONE_RESET = 16'd40797;
    localparam logic signed [24:0] REFLON_RESET = -25'sd6389760;
    localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;
    localparam logic [24:0] DEG_TO_RAD_Q30 = 25'd18740330;
    localparam logic signed [22:0] RAD_TO_DEG_Q16 = 23'sd3754937;
    localparam int FRAC_BITS = 14;
    localparam logic [0:0] ADDR_CONE = 1'b0;
    localparam logic [0:0] ADDR_REFLON = 1'b1;

    function automatic logic signed [31:0] atan_q30(input int i);
        logic signed [31:0] r;
        begin
            case (i)
                0: r = 32'sh3243F6A8;
                1: r = 32'sh1DAC6705;
                2: r = 32'sh0FADBAFC;
                3: r = 32'sh07F56EA6;
                4: r = 32'sh03FEAB76;
                5: r = 32'sh01FFD55B;
                6: r = 32'sh00FFFAAA;
                7: r = 32'sh007FFF55;
                8: r = 32'sh003FFFEA;
                9: r = 32'sh001FFFFD;
                10: r = 32'sh000FFFFF;
                11: r = 32'sh0007FFFF;
                12: r = 32'sh0003FFFF;
                13: r = 32'sh0001FFFF;
                14: r = 32'sh0000FFFF;
                15: r = 32'sh00007FFF;
                16: r = 32'sh00003FFF;
                17: r = 32'sh00001FFF;
                18: r = 32'sh00000FFF;
                19: r = 32'sh000007FF;
                20: r = 32'sh000003FF;
                21: r = 32'sh000001FF;
                22: r = 32'sh000000FF;
                23: r = 32'sh0000007F;
                default: r = 32'sh0;
            endcase
            return r;
        end
    endfunction
endpackage
`default_nettype wire

FILE: hdl/grid_wind_rotate_speed_dir.sv
// ----------------------------------------------------------------------------
// Grid-to-earth wind rotation with speed and direction
// Rotates grid winds by the cone angle, then gives speed and direction.
// ----------------------------------------------------------------------------
// One transfer is accepted per clock while in_stall is low. Each result passes the
// front stages, the rotation CORDIC, the mid stages, the vectoring CORDIC and the
// back stages in turn, N being CORDIC_STAGES capped at 24; each CORDIC pipeline runs
// one iteration per stage. A stall holds every stage in place.
`default_nettype none
module grid_wind_rotate_speed_dir #(
    parameter int CORDIC_STAGES = gwr_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [24:0] longitude,
    input  wire logic signed [15:0] u_grid,
    input  wire logic signed [15:0] v_grid,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [15:0]      u_earth,
    output logic signed [15:0]      v_earth,
    output logic [15:0]             wind_speed,
    output logic signed [16:0]      wind_direction
);
    import gwr_pkg::*;
`include "assert_macros.svh"

    localparam int N = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
    // Front: 5 stages, rotation: N, mid: 2, vectoring: N, back: 3.
    localparam int R0 = 4;
    localparam int V0 = R0 + N + 2;
    localparam int DEPTH = V0 + N + 4;
    localparam int CW = 40;
    localparam logic signed [CW-1:0] HALF_LSB = CW'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [46:0] TURN = 47'sd360 <<< 32;
    localparam logic signed [46:0] HALFT = 47'sd180 <<< 32;
    localparam logic signed [46:0] QUART = 47'sd90 <<< 32;

    logic [15:0]        cone_reg;
    logic signed [24:0] reflon_reg;
    logic               adv;
    logic [DEPTH-1:0]   vld_reg;

    // Pipeline payload arrays, one entry per stage.
    logic signed [CW-1:0] x_reg [DEPTH];
    logic signed [CW-1:0] y_reg [DEPTH];
    logic signed [46:0]   z_reg [DEPTH];
    logic signed [15:0]   ue_reg [DEPTH];
    logic signed [15:0]   ve_reg [DEPTH];
    logic                 calm_reg [DEPTH];
    logic signed [25:0]   off_reg;
    logic signed [24:0]   ug_reg, vg_reg;

    assign pready = 1'b1;
    assign adv = !(vld_reg[DEPTH-1] && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cone_reg <= CONE_RESET;
            reflon_reg <= REFLON_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[2])
                ADDR_CONE: cone_reg <= pwdata[15:0];
                ADDR_REFLON: reflon_reg <= pwdata[24:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            ADDR_CONE: prdata = {16'd0, cone_reg};
            ADDR_REFLON: prdata = {{7{reflon_reg[24]}}, reflon_reg};
            default: prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[DEPTH-2:0], in_valid};
    end

    // Working signals for the combinational stage steps.
    logic signed [46:0] prod_next, w_next, t_next, tf_next;
    logic               flip_next;
    logic [38:0]        mag_next;
    logic [63:0]        zr_next;
    logic signed [CW-1:0] rx_r, ry_r, sxr, syr;
    logic signed [15:0] ue_next, ve_next;
    logic signed [CW-1:0] xo;
    logic signed [47:0] spd_w;
    logic signed [56:0] ang_w;
    logic signed [31:0] ang_n;
    logic signed [17:0] wr_n;

    function automatic logic signed [15:0] sat16(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] s;
        begin
            s = (v + HALF_LSB) >>> FRAC_BITS;
            if (s > 32767) return 16'sh7FFF;
            if (s < -32768) return -16'sh8000;
            return s[15:0];
        end
    endfunction

    always_comb
    begin
        prod_next = 47'(signed'({1'b0, cone_reg})) * 47'(off_reg);
        w_next = z_reg[0];
        if (w_next >= TURN) w_next = w_next - TURN;
        if (w_next < 0) w_next = w_next + TURN;
        if (w_next < 0) w_next = w_next + TURN;
        t_next = (w_next == 0) ? 47'sd0 : TURN - w_next;
        if (t_next >= HALFT) t_next = t_next - TURN;
        flip_next = 1'b0;
        tf_next = t_next;
        if (t_next > QUART)
        begin
            flip_next = 1'b1;
            tf_next = t_next - HALFT;
        end
        else if (t_next < -QUART)
        begin
            flip_next = 1'b1;
            tf_next = t_next + HALFT;
        end
        mag_next = (z_reg[2] < 0) ? 39'(-z_reg[2]) : 39'(z_reg[2]);
        zr_next = (64'(mag_next >> 8) * 64'(DEG_TO_RAD_Q30) + (64'd1 << 23)) >> 24;
        rx_r = 40'(x_reg[1]);
        ry_r = 40'(y_reg[1]);
    end

    // Front stages: offset, angle wrap, radians, scaled vector.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            off_reg <= 26'(longitude) - 26'(reflon_reg);
            ug_reg <= 25'(u_grid);
            vg_reg <= 25'(v_grid);
            // Stage 1: raw angle product and gain-scaled vector.
            x_reg[0] <= CW'((48'(ug_reg) * 48'(GAIN_Q30)) >>> 16);
            y_reg[0] <= CW'((48'(vg_reg) * 48'(GAIN_Q30)) >>> 16);
            z_reg[0] <= prod_next;
            // Stage 2: wrap and fold into a quarter turn.
            z_reg[1] <= tf_next;
            calm_reg[1] <= flip_next;
            x_reg[1] <= x_reg[0];
            y_reg[1] <= y_reg[0];
            // Stage 3: apply the half-turn.
            z_reg[2] <= z_reg[1];
            x_reg[2] <= calm_reg[1] ? -rx_r : rx_r;
            y_reg[2] <= calm_reg[1] ? -ry_r : ry_r;
            // Stage 4: degrees to radians.
            z_reg[3] <= (z_reg[2] < 0) ? -47'(zr_next) : 47'(zr_next);
            x_reg[3] <= x_reg[2];
            y_reg[3] <= y_reg[2];
        end
    end

    // The wrap works on the raw product held in z_reg[0], one stage after it.
    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_rot
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    if (z_reg[R0+g-1] >= 0)
                    begin
                        x_reg[R0+g] <= x_reg[R0+g-1] - (y_reg[R0+g-1] >>> g);
                        y_reg[R0+g] <= y_reg[R0+g-1] + (x_reg[R0+g-1] >>> g);
                        z_reg[R0+g] <= z_reg[R0+g-1] - 47'(atan_q30(g));
                    end
                    else
                    begin
                        x_reg[R0+g] <= x_reg[R0+g-1] + (y_reg[R0+g-1] >>> g);
                        y_reg[R0+g] <= y_reg[R0+g-1] - (x_reg[R0+g-1] >>> g);
                        z_reg[R0+g] <= z_reg[R0+g-1] + 47'(atan_q30(g));
                    end
                end
            end
        end
    endgenerate

    always_comb
    begin
        ue_next = sat16(x_reg[R0+N-1]);
        ve_next = sat16(y_reg[R0+N-1]);
        sxr = CW'((48'(ue_reg[R0+N]) * 48'(GAIN_Q30)) >>> 16);
        syr = CW'((48'(ve_reg[R0+N]) * 48'(GAIN_Q30)) >>> 16);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ue_reg[R0+N] <= ue_next;
            ve_reg[R0+N] <= ve_next;
            ue_reg[V0-1] <= ue_reg[R0+N];
            ve_reg[V0-1] <= ve_reg[R0+N];
            calm_reg[V0-1] <= (ue_reg[R0+N] == 0) && (ve_reg[R0+N] == 0);
            if (ue_reg[R0+N] < 0)
            begin
                if (ve_reg[R0+N] >= 0)
                begin
                    x_reg[V0-1] <= syr;
                    y_reg[V0-1] <= -sxr;
                    z_reg[V0-1] <= 47'(atan_q30(0)) <<< 1;
                end
                else
                begin
                    x_reg[V0-1] <= -syr;
                    y_reg[V0-1] <= sxr;
                    z_reg[V0-1] <= -(47'(atan_q30(0)) <<< 1);
                end
            end
            else
            begin
                x_reg[V0-1] <= sxr;
                y_reg[V0-1] <= syr;
                z_reg[V0-1] <= '0;
            end
        end
    end

    generate
        for (g = 0; g < N; g++)
        begin : g_vec
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    ue_reg[V0+g] <= ue_reg[V0+g-1];
                    ve_reg[V0+g] <= ve_reg[V0+g-1];
                    calm_reg[V0+g] <= calm_reg[V0+g-1];
                    if (y_reg[V0+g-1] >= 0)
                    begin
                        x_reg[V0+g] <= x_reg[V0+g-1] + (y_reg[V0+g-1] >>> g);
                        y_reg[V0+g] <= y_reg[V0+g-1] - (x_reg[V0+g-1] >>> g);
                        z_reg[V0+g] <= z_reg[V0+g-1] + 47'(atan_q30(g));
                    end
                    else
                    begin
                        x_reg[V0+g] <= x_reg[V0+g-1] - (y_reg[V0+g-1] >>> g);
                        y_reg[V0+g] <= y_reg[V0+g-1] + (x_reg[V0+g-1] >>> g);
                        z_reg[V0+g] <= z_reg[V0+g-1] - 47'(atan_q30(g));
                    end
                end
            end
        end
    endgenerate

    localparam int E = V0 + N;
    always_comb
    begin
        xo = x_reg[E-1];
        spd_w = (48'(xo) + 48'(HALF_LSB)) >>> FRAC_BITS;
        ang_w = 57'(signed'(z_reg[E-1][33:0])) * 57'(RAD_TO_DEG_Q16) + (57'sd1 <<< 38);
        ang_n = calm_reg[E-1] ? 32'sd0 : 32'(ang_w >>> 39);
        wr_n = 18'(z_reg[E]);
        if (wr_n < 0) wr_n = wr_n + 18'sd46080;
        if (wr_n >= 18'sd46080) wr_n = wr_n - 18'sd46080;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // Back stage 1: speed rounding and angle to degrees.
            ue_reg[E] <= ue_reg[E-1];
            ve_reg[E] <= ve_reg[E-1];
            z_reg[E] <= 47'(ang_n);
            if (calm_reg[E-1] || spd_w < 0)
                x_reg[E] <= '0;
            else if (spd_w > 65535)
                x_reg[E] <= CW'(65535);
            else
                x_reg[E] <= CW'(spd_w);
            // Back stage 2: wrap of the direction.
            ue_reg[E+1] <= ue_reg[E];
            ve_reg[E+1] <= ve_reg[E];
            x_reg[E+1] <= x_reg[E];
            z_reg[E+1] <= 47'(wr_n);
            // Output register.
            u_earth <= ue_reg[E+1];
            v_earth <= ve_reg[E+1];
            wind_speed <= x_reg[E+1][15:0];
            wind_direction <= 17'(18'sd34560 - z_reg[E+1][17:0]);
        end
    end

    assign out_valid = vld_reg[DEPTH-1];

    `ASSERT_IMPLIES(a_stall_hold, clk, rst_n, out_valid && out_stall, in_stall)
    `ASSERT_NEXT(a_out_keep, clk, rst_n, out_valid && out_stall, out_valid)
    `ASSERT_IMPLIES(a_speed_calm, clk, rst_n,
        out_valid && u_earth == 0 && v_earth == 0, wind_speed == 0)
endmodule
`default_nettype wire
